/* sv/crossfade_wavetable_mixer_top_defines.svh */
// ----------------------------------------------------------------------------
// Crossfade wavetable mixer - assertion macros
// Shared property wrappers, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef CROSSFADE_WAVETABLE_MIXER_TOP_DEFINES_SVH
`define CROSSFADE_WAVETABLE_MIXER_TOP_DEFINES_SVH

// same-cycle implication
`define CWM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CWM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/cwm_pkg.sv */
// ----------------------------------------------------------------------------
// cwm_pkg
// Types and constants shared by the mixer controller, datapath and top.
// ----------------------------------------------------------------------------
package cwm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MASTER_W = 11;
	localparam int LEVEL_W  = 10;
	localparam int POS_W    = 10;
	localparam int LEN_W    = 11;
	localparam int CODE_W   = 12;
	localparam int SCALED_W = 14;
	localparam int PROD_W   = SAMPLE_W + MASTER_W + 1;
	localparam int RECIP_W  = 21;
	localparam int RECIP_SHIFT = 27;

	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_SELECT = 2'd1;
	localparam logic [1:0] REQ_LOAD   = 2'd2;

	localparam logic [LEVEL_W-1:0] LEVEL_CEIL = 10'd1000;
	localparam logic [CODE_W-1:0]  CODE_MAX   = 12'd4095;
	// ceil(2^27 / 125): x/16000 = ((x >> 7) * RECIP_MULT) >> 27, exact below 2^20
	localparam logic [RECIP_W-1:0] RECIP_MULT = 21'd1073742;

	typedef struct packed {
		logic start;
		logic rd;
		logic mul;
		logic scl;
		logic acc;
		logic next;
		logic div_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic mix_go;
		logic voice_act;
		logic last_voice;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

/* sv/crossfade_wavetable_mixer_top.sv */
// ----------------------------------------------------------------------------
// crossfade_wavetable_mixer_top
// Looping wavetable voices mixed with crossfade levels into a 12-bit code.
// ----------------------------------------------------------------------------
// Use:
//   Request channel (req_valid / req_stall) carries one item: a load writes
//   one table word (is_last also sets the voice's loop length), a select
//   makes a voice current, a tick steps the master ramp and may mix.
//   Result channel (dac_valid / dac_stall) carries dac_code, one item per
//   tick that mixes (voice selected and master level above zero).
// Timing:
//   Load, select and idle ticks do not stall the request channel. A mixing
//   tick walks all NUM_VOICES voices; each mixed voice costs read, multiply,
//   scale and accumulate on the one shared scaling path, and the restoring
//   divider then adds one bit per cycle over the SVW-bit accumulator (30 bits
//   at sixteen voices).
// Reset:
//   Levels, positions, lengths, master ramp and selection clear at once.
//   Wave tables are not cleared; unwritten words read as garbage.
// Stall:
//   The result sits in an output register; the next item is accepted
//   meanwhile, and a later mix waits at its end until the register frees.
// ----------------------------------------------------------------------------
`include "crossfade_wavetable_mixer_top_defines.svh"

module crossfade_wavetable_mixer_top #(
	parameter int NUM_VOICES  = 16,
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [1:0]                          req_type,
	input  logic [cwm_pkg::MASTER_W-1:0]        target_level,
	input  logic [3:0]                          voice,
	input  logic [cwm_pkg::POS_W-1:0]           table_addr,
	input  logic signed [cwm_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                is_last,
	output logic                                dac_valid,
	input  logic                                dac_stall,
	output logic [cwm_pkg::CODE_W-1:0]          dac_code
);

	cwm_pkg::cmd_t cmd;
	cwm_pkg::sts_t sts;
	logic          take;

	// item accepted this cycle
	assign take = req_valid && !req_stall;

	cwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cwm_dpath #(
		.NUM_VOICES  (NUM_VOICES),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.req_type     (req_type),
		.target_level (target_level),
		.voice        (voice),
		.table_addr   (table_addr),
		.sample_value (sample_value),
		.is_last      (is_last),
		.cmd          (cmd),
		.sts          (sts),
		.dac_valid    (dac_valid),
		.dac_stall    (dac_stall),
		.dac_code     (dac_code)
	);

	// a fresh result only ever comes out of a busy mix
	`CWM_ASSERT_NOW(a_result_from_mix, $rose(dac_valid), $past(req_stall), "result without mix")
	// a mixing tick holds off further items
	`CWM_ASSERT_NXT(a_mix_busy, take && sts.mix_go, req_stall, "mix did not stall input")
	// loads and selects never raise a result
	`CWM_ASSERT_NXT(a_no_result_cfg, take && req_type != cwm_pkg::REQ_TICK, !$rose(dac_valid), "result from non-tick item")

endmodule

/* sv/cwm_ctrl.sv */
// ----------------------------------------------------------------------------
// cwm_ctrl
// Mixing-tick sequencer: per-voice read/mul/scale/accumulate, divide, output.
// ----------------------------------------------------------------------------
module cwm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cwm_pkg::sts_t sts,
	output cwm_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_MUL, S_SCL, S_ACC, S_DVI, S_DIV, S_OUT
	} state_t;

	state_t state_q, state_nx;
	logic   stall_q;

	assign req_stall = stall_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && sts.mix_go) begin
					cmd.start = 1'b1;
					state_nx  = S_RD;
				end
			end
			S_RD: begin
				if (sts.voice_act) begin
					cmd.rd   = 1'b1;
					state_nx = S_MUL;
				end else if (sts.last_voice) begin
					state_nx = S_DVI;
				end else begin
					cmd.next = 1'b1;
				end
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = S_SCL;
			end
			S_SCL: begin
				cmd.scl  = 1'b1;
				state_nx = S_ACC;
			end
			S_ACC: begin
				cmd.acc  = 1'b1;
				cmd.next = !sts.last_voice;
				state_nx = sts.last_voice ? S_DVI : S_RD;
			end
			S_DVI: begin
				cmd.div_start = 1'b1;
				state_nx      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_nx = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			stall_q <= (state_nx != S_IDLE);
		end
	end

endmodule

/* sv/cwm_dpath.sv */
// ----------------------------------------------------------------------------
// cwm_dpath
// Wave memory, voice registers, scaling multipliers, accumulators, divider
// and the output register.
// ----------------------------------------------------------------------------
module cwm_dpath #(
	parameter int NUM_VOICES  = 16,
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  take,
	input  logic [1:0]                            req_type,
	input  logic [cwm_pkg::MASTER_W-1:0]          target_level,
	input  logic [3:0]                            voice,
	input  logic [cwm_pkg::POS_W-1:0]             table_addr,
	input  logic signed [cwm_pkg::SAMPLE_W-1:0]   sample_value,
	input  logic                                  is_last,
	input  cwm_pkg::cmd_t                         cmd,
	output cwm_pkg::sts_t                         sts,
	output logic                                  dac_valid,
	input  logic                                  dac_stall,
	output logic [cwm_pkg::CODE_W-1:0]            dac_code
);

	localparam int VW     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int TD_EFF = (TABLE_DEPTH < 1024) ? TABLE_DEPTH : 1024;
	localparam int PW     = $clog2(TD_EFF);
	localparam int MEM_D  = 2 ** (VW + PW);
	localparam int LW     = $clog2(NUM_VOICES * 1000 + 1);
	localparam int TERM_W = cwm_pkg::LEVEL_W + 1 + cwm_pkg::SCALED_W;
	localparam int SVW    = TERM_W + VW + 1;
	localparam int CW     = $clog2(SVW + 1);

	// wave tables, one row per voice
	logic [cwm_pkg::SAMPLE_W-1:0] mem [MEM_D];
	logic [cwm_pkg::SAMPLE_W-1:0] rdata_q;

	logic [cwm_pkg::LEN_W-1:0]   len_q [NUM_VOICES];
	logic [cwm_pkg::POS_W-1:0]   pos_q [NUM_VOICES];
	logic [cwm_pkg::LEVEL_W-1:0] lvl_q [NUM_VOICES];

	logic [VW-1:0]                 cur_q;
	logic                          has_cur_q;
	logic [cwm_pkg::MASTER_W-1:0]  master_q;
	logic [cwm_pkg::MASTER_W-1:0]  mmix_q;
	logic [1:0]                    ramp_q;
	logic [VW-1:0]                 vidx_q;

	logic signed [cwm_pkg::PROD_W-1:0]   prod_s1;
	logic signed [cwm_pkg::SCALED_W-1:0] scaled_s2;
	logic signed [SVW-1:0]               sum_val_q;
	logic [LW-1:0]                       sum_lvl_q;

	logic [LW-1:0]  rem_q;
	logic [SVW-1:0] quo_q;
	logic           neg_q;
	logic [CW-1:0]  cnt_q;

	logic [cwm_pkg::CODE_W-1:0] code_q;
	logic                       valid_q;

	logic                                 voice_ok, addr_ok;
	logic [VW-1:0]                        vin;
	logic                                 cur_hit;
	logic [cwm_pkg::PROD_W-1:0]           mag;
	logic [19:0]                          ymag;
	logic [20+cwm_pkg::RECIP_W-1:0]       recip;
	logic signed [cwm_pkg::SCALED_W-1:0]  qpos;
	logic signed [TERM_W-1:0]             term;
	logic [cwm_pkg::LEN_W-1:0]            pos_inc;
	logic [LW:0]                          shifted;
	logic                                 fits;
	logic [cwm_pkg::CODE_W-1:0]           code_nx;

	assign voice_ok = ({3'b0, voice} < 7'(NUM_VOICES));
	assign addr_ok  = ({7'b0, table_addr} < 17'(TABLE_DEPTH));
	assign vin      = VW'(voice);
	assign cur_hit  = (vidx_q == cur_q);

	assign sts.mix_go     = (req_type == cwm_pkg::REQ_TICK) && has_cur_q && (master_q != '0);
	assign sts.voice_act  = (lvl_q[vidx_q] != '0) || cur_hit;
	assign sts.last_voice = (vidx_q == VW'(NUM_VOICES - 1));
	assign sts.div_last   = (cnt_q == CW'(1));
	assign sts.out_free   = !valid_q || !dac_stall;

	// truncating divide by 16000 on the magnitude
	assign mag   = prod_s1[cwm_pkg::PROD_W-1] ? cwm_pkg::PROD_W'(-prod_s1)
	                                          : cwm_pkg::PROD_W'(prod_s1);
	assign ymag  = mag[26:7];
	assign recip = ymag * cwm_pkg::RECIP_MULT;
	assign qpos  = $signed(recip[cwm_pkg::RECIP_SHIFT +: cwm_pkg::SCALED_W]);

	assign term    = $signed({1'b0, lvl_q[vidx_q]}) * scaled_s2;
	assign pos_inc = {1'b0, pos_q[vidx_q]} + 1'b1;
	assign shifted = {rem_q, quo_q[SVW-1]};
	assign fits    = (shifted >= {1'b0, sum_lvl_q});

	// saturate 2048 + signed average into the code range
	always_comb begin
		if (sum_lvl_q == '0)
			code_nx = 12'd2048;
		else if (neg_q)
			code_nx = (quo_q > SVW'(2048)) ? '0 : 12'(SVW'(2048) - quo_q);
		else
			code_nx = (quo_q > SVW'(2047)) ? cwm_pkg::CODE_MAX : 12'(SVW'(2048) + quo_q);
	end

	always_ff @(posedge clk) begin
		if (take && req_type == cwm_pkg::REQ_LOAD && voice_ok && addr_ok)
			mem[{vin, PW'(table_addr)}] <= sample_value;
		if (cmd.rd)
			rdata_q <= mem[{vidx_q, PW'(pos_q[vidx_q])}];
		if (cmd.mul)
			prod_s1 <= $signed(rdata_q) * $signed({1'b0, mmix_q});
		if (cmd.scl)
			scaled_s2 <= prod_s1[cwm_pkg::PROD_W-1] ? -qpos : qpos;
		if (take && sts.mix_go)
			mmix_q <= master_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				len_q[i] <= '0;
				pos_q[i] <= '0;
				lvl_q[i] <= '0;
			end
			cur_q     <= '0;
			has_cur_q <= 1'b0;
			master_q  <= '0;
			ramp_q    <= '0;
			vidx_q    <= '0;
			sum_val_q <= '0;
			sum_lvl_q <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			neg_q     <= 1'b0;
			cnt_q     <= '0;
			code_q    <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (take) begin
				unique case (req_type)
					cwm_pkg::REQ_TICK: begin
						if (ramp_q == 2'd2) begin
							ramp_q <= '0;
							if (master_q < target_level)
								master_q <= master_q + 1'b1;
							else if (master_q > target_level)
								master_q <= master_q - 1'b1;
						end else begin
							ramp_q <= ramp_q + 1'b1;
						end
					end
					cwm_pkg::REQ_SELECT: begin
						if (voice_ok) begin
							cur_q     <= vin;
							has_cur_q <= 1'b1;
						end
					end
					cwm_pkg::REQ_LOAD: begin
						if (voice_ok && addr_ok && is_last)
							len_q[vin] <= cwm_pkg::LEN_W'(table_addr) + 1'b1;
					end
					default: ;
				endcase
			end
			if (cmd.start) begin
				vidx_q    <= '0;
				sum_val_q <= '0;
				sum_lvl_q <= '0;
			end
			if (cmd.next)
				vidx_q <= vidx_q + 1'b1;
			if (cmd.acc) begin
				sum_val_q     <= sum_val_q + SVW'(term);
				sum_lvl_q     <= sum_lvl_q + LW'(lvl_q[vidx_q]);
				pos_q[vidx_q] <= (pos_inc >= len_q[vidx_q]) ? '0
				                 : cwm_pkg::POS_W'(pos_inc);
				if (!cur_hit)
					lvl_q[vidx_q] <= lvl_q[vidx_q] - 1'b1;
				else if (lvl_q[vidx_q] < cwm_pkg::LEVEL_CEIL)
					lvl_q[vidx_q] <= lvl_q[vidx_q] + 1'b1;
			end
			if (cmd.div_start) begin
				rem_q <= '0;
				quo_q <= sum_val_q[SVW-1] ? SVW'(-sum_val_q) : SVW'(sum_val_q);
				neg_q <= sum_val_q[SVW-1];
				cnt_q <= CW'(SVW);
			end
			if (cmd.div_step) begin
				rem_q <= fits ? LW'(shifted - {1'b0, sum_lvl_q}) : LW'(shifted);
				quo_q <= {quo_q[SVW-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.out_load) begin
				code_q  <= code_nx;
				valid_q <= 1'b1;
			end else if (valid_q && !dac_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign dac_valid = valid_q;
	assign dac_code  = code_q;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - crossfade wavetable mixer regression
// Drives load, select, tick and spare items into the mixer. A scoreboard
// predicts every converter code and compares each result item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] REQ_SPARE = 2'd3;  // unused request code, block ignores it
	localparam int NV = 16;
	localparam int DEPTH = 1024;
	localparam int RANDOM_ITEMS = 1500;
	localparam int RAMP_TICKS = 450;          // lifts the master level well clear of zero
	localparam int HOLDOFF_CYCLES = 3000;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int TAIL_CYCLES = 200;         // longer than one mixing tick

	typedef struct {
		logic [1:0]                   kind;
		logic [cwm_pkg::MASTER_W-1:0] target;
		logic [3:0]                   voice;
		logic [cwm_pkg::POS_W-1:0]    addr;
		logic signed [cwm_pkg::SAMPLE_W-1:0] sample;
		logic                         last;
	} mix_req_t;

	// Scoreboard: own copy of the mixer state, queue of converter codes due.
	class mix_scoreboard;
		logic signed [cwm_pkg::SAMPLE_W-1:0] wave[NV][DEPTH];
		logic [cwm_pkg::LEN_W-1:0]    loop_len[NV];
		logic [cwm_pkg::POS_W-1:0]    rd_pos[NV];
		logic [cwm_pkg::LEVEL_W-1:0]  fade[NV];
		logic [3:0]                   cur;
		bit                           selected;
		logic [cwm_pkg::MASTER_W-1:0] master;
		logic [1:0]                   ramp_cnt;
		logic [cwm_pkg::CODE_W-1:0]   codes_due[$];
		int mismatches;
		int codes_seen;

		function new();
			for (int v = 0; v < NV; v++) begin
				loop_len[v] = '0;
				rd_pos[v] = '0;
				fade[v] = '0;
			end
			cur = '0;
			selected = 0;
			master = '0;
			ramp_cnt = '0;
			mismatches = 0;
			codes_seen = 0;
		endfunction

		function logic [cwm_pkg::CODE_W-1:0] mix_code();
			longint acc_val, acc_lvl, scaled, avg, code;
			bit is_cur;
			acc_val = 0;
			acc_lvl = 0;
			avg = 0;
			for (int v = 0; v < NV; v++) begin
				is_cur = (v == cur);
				if (fade[v] == 0 && !is_cur)
					continue;
				scaled = (longint'(wave[v][rd_pos[v]]) * longint'(master)) / 16000;
				acc_val += longint'(fade[v]) * scaled;
				acc_lvl += longint'(fade[v]);
				if (int'(rd_pos[v]) + 1 >= int'(loop_len[v]))
					rd_pos[v] = '0;
				else
					rd_pos[v] = rd_pos[v] + 1'b1;
				if (!is_cur)
					fade[v] = fade[v] - 1'b1;
				else if (fade[v] < cwm_pkg::LEVEL_CEIL)
					fade[v] = fade[v] + 1'b1;
			end
			if (acc_lvl > 0)
				avg = acc_val / acc_lvl;
			code = 2048 + avg;
			if (code < 0)
				code = 0;
			if (code > 4095)
				code = 4095;
			return code[cwm_pkg::CODE_W-1:0];
		endfunction

		function void note(mix_req_t r);
			case (r.kind)
				cwm_pkg::REQ_TICK: begin
					if (selected && master > 0)
						codes_due.push_back(mix_code());
					ramp_cnt = ramp_cnt + 1'b1;
					if (ramp_cnt > 2) begin
						ramp_cnt = '0;
						if (master < r.target)
							master = master + 1'b1;
						else if (master > r.target)
							master = master - 1'b1;
					end
				end
				cwm_pkg::REQ_SELECT: begin
					cur = r.voice;
					selected = 1;
				end
				cwm_pkg::REQ_LOAD: begin
					wave[r.voice][r.addr] = r.sample;
					if (r.last)
						loop_len[r.voice] = cwm_pkg::LEN_W'(r.addr) + 1'b1;
				end
				default: ;
			endcase
		endfunction

		function void check(logic [cwm_pkg::CODE_W-1:0] got);
			logic [cwm_pkg::CODE_W-1:0] want;
			codes_seen++;
			if (codes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected dac_code %0d, none pending", got);
				return;
			end
			want = codes_due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("dac_code mismatch: expected %0d, got %0d", want, got);
			end
		endfunction

		function int pending();
			return codes_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [1:0] req_type;
	logic [cwm_pkg::MASTER_W-1:0] target_level;
	logic [3:0] voice;
	logic [cwm_pkg::POS_W-1:0] table_addr;
	logic signed [cwm_pkg::SAMPLE_W-1:0] sample_value;
	logic is_last;
	logic dac_valid;
	logic dac_stall;
	logic [cwm_pkg::CODE_W-1:0] dac_code;

	mix_scoreboard sb = new();

	// Which table words the stimulus has written; a mixed voice must never
	// read a word left untouched since reset.
	bit written[NV][DEPTH];
	int items_sent = 0;
	int cycles = 0;
	bit calm = 0;           // no idling on either side
	bit holdoff_req = 0;

	crossfade_wavetable_mixer_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.req_type(req_type), .target_level(target_level), .voice(voice),
		.table_addr(table_addr), .sample_value(sample_value), .is_last(is_last),
		.dac_valid(dac_valid), .dac_stall(dac_stall), .dac_code(dac_code)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		req_valid = 0;
		req_type = cwm_pkg::REQ_TICK;
		target_level = '0;
		voice = '0;
		table_addr = '0;
		sample_value = '0;
		is_last = 0;
		dac_stall = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	// Watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("crossfade_wavetable_mixer_top regression: fail");
		$finish;
	end

	// Offer one item and hold it until accepted; stall is read at the falling
	// edge, where it is settled for the coming rising edge.
	task automatic send(mix_req_t r);
		bit taken;
		req_valid <= 1;
		req_type <= r.kind;
		target_level <= r.target;
		voice <= r.voice;
		table_addr <= r.addr;
		sample_value <= r.sample;
		is_last <= r.last;
		do begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end while (!taken);
		sb.note(r);
		if (r.kind == cwm_pkg::REQ_LOAD)
			written[r.voice][r.addr] = 1;
		items_sent++;
		if (!calm && $urandom_range(99) < 28) begin
			req_valid <= 0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	function automatic mix_req_t mk(logic [1:0] k, int tgt, int v, int a, int s, bit l);
		mix_req_t r;
		r.kind = k;
		r.target = cwm_pkg::MASTER_W'(tgt);
		r.voice = 4'(v);
		r.addr = cwm_pkg::POS_W'(a);
		r.sample = cwm_pkg::SAMPLE_W'(s);
		r.last = l;
		return r;
	endfunction

	function automatic bit prefix_written(int v, int a);
		for (int i = 0; i <= a; i++)
			if (!written[v][i])
				return 0;
		return 1;
	endfunction

	// Random item, kept well formed: a loop length is only set over written
	// words, and only voices with word zero written are selected.
	function automatic mix_req_t random_item();
		int pick, v, a;
		mix_req_t r;
		pick = $urandom_range(99);
		v = $urandom_range(NV - 1);
		a = ($urandom_range(99) < 85) ? $urandom_range(15) : $urandom_range(DEPTH - 1);
		r = mk(cwm_pkg::REQ_TICK, $urandom_range(2000), v, a, $urandom, 0);
		if (pick < 48) begin
			r.kind = cwm_pkg::REQ_LOAD;
			r.last = prefix_written(v, a) && $urandom_range(99) < 30;
		end else if (pick < 56 && written[v][0]) begin
			r.kind = cwm_pkg::REQ_SELECT;
		end else if (pick < 60) begin
			r.kind = REQ_SPARE;
			r.last = $urandom_range(1);
		end
		return r;
	endfunction

	// Receiver: random stalls, one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				holdoff_req = 0;
				dac_stall <= 1;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			dac_stall <= (!calm && $urandom_range(99) < 28);
		end
	end

	// Result monitor: a code is taken at the edge after a falling edge that
	// shows valid high and stall low.
	initial begin
		forever begin
			@(negedge clk);
			if (arst_n && dac_valid && !dac_stall)
				sb.check(dac_code);
		end
	end

	initial begin
		int waited;
		@(posedge arst_n);
		@(posedge clk);

		// Directed: field extremes, ignored request code, idle ticks.
		send(mk(REQ_SPARE, 2047, 15, 1023, 16'hffff, 1));
		send(mk(cwm_pkg::REQ_TICK, 0, 0, 0, 0, 0));        // idle tick, nothing selected
		send(mk(cwm_pkg::REQ_LOAD, 0, 0, 0, -32768, 0));
		send(mk(cwm_pkg::REQ_LOAD, 0, 0, 1, 32767, 1));
		send(mk(cwm_pkg::REQ_LOAD, 0, 15, 1023, 32767, 0));
		send(mk(cwm_pkg::REQ_LOAD, 0, 15, 0, 32767, 1));   // length one
		send(mk(cwm_pkg::REQ_LOAD, 0, 3, 0, -12345, 0));   // voice three keeps length zero
		for (int i = 0; i < 8; i++)
			send(mk(cwm_pkg::REQ_LOAD, 0, 7, i, $urandom, i == 7));
		send(mk(cwm_pkg::REQ_TICK, 2000, 0, 0, 0, 0));

		// Master ramp up before anything is selected: no results yet.
		for (int i = 0; i < RAMP_TICKS; i++)
			send(mk(cwm_pkg::REQ_TICK, 2000, 0, 0, 0, 0));

		// First mix of a fresh voice: every level zero, midscale code.
		send(mk(cwm_pkg::REQ_SELECT, 0, 15, 0, 0, 0));
		send(mk(cwm_pkg::REQ_TICK, 2000, 0, 0, 0, 0));
		send(mk(cwm_pkg::REQ_TICK, 2000, 0, 0, 0, 0));
		send(mk(cwm_pkg::REQ_SELECT, 0, 0, 0, 0, 0));      // crossfade 15 -> 0
		repeat (3) send(mk(cwm_pkg::REQ_TICK, 2000, 0, 0, 0, 0));
		send(mk(cwm_pkg::REQ_SELECT, 0, 3, 0, 0, 0));      // zero-length voice
		repeat (3) send(mk(cwm_pkg::REQ_TICK, 0, 0, 0, 0, 0));
		send(mk(cwm_pkg::REQ_SELECT, 0, 7, 0, 0, 0));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 500)
				holdoff_req = 1;
			if (n == 900) begin
				// Sender waits until every code due has come out.
				req_valid <= 0;
				while (sb.pending() > 0)
					@(posedge clk);
			end
			calm = (n >= 1000 && n < 1300);
			send(random_item());
		end
		req_valid <= 0;
		calm = 0;

		waited = 0;
		while (sb.pending() > 0 || waited < TAIL_CYCLES) begin
			@(posedge clk);
			if (sb.pending() == 0)
				waited++;
		end

		$display("sent %0d items, checked %0d converter codes, %0d mismatches",
			items_sent, sb.codes_seen, sb.mismatches);
		$display("covered master ramp, crossfades, loop wrap, idle ticks and stalls");
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("crossfade_wavetable_mixer_top regression: pass");
		else
			$display("crossfade_wavetable_mixer_top regression: fail");
		$finish;
	end

endmodule

/* crossfade_wavetable_mixer_top.f */
+incdir+sv
sv/cwm_pkg.sv
sv/cwm_ctrl.sv
sv/cwm_dpath.sv
sv/crossfade_wavetable_mixer_top.sv
tb/tb_top.sv
